FILE: hw/rtl/per_source_rate_limiter_defines.svh
// ---------------------------------------------------------------------------
// per_source_rate_limiter_defines
// assertion helpers used by the rate limiter engine
// ---------------------------------------------------------------------------
`ifndef PER_SOURCE_RATE_LIMITER_DEFINES_SVH
`define PER_SOURCE_RATE_LIMITER_DEFINES_SVH

// same-cycle implication
`define PSRL_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSRL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/psrl_pkg.sv
// ---------------------------------------------------------------------------
// psrl_pkg
// types, codes and defaults of the per-source rate limiter
// ---------------------------------------------------------------------------
package psrl_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int STAMPS_DEF  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] OP_QUERY_LIMITED = 3'd0;
   localparam logic [2:0] OP_RECORD_REQ    = 3'd1;
   localparam logic [2:0] OP_RECORD_FAIL   = 3'd2;
   localparam logic [2:0] OP_QUERY_BLOCKED = 3'd3;
   localparam logic [2:0] OP_CLEANUP       = 3'd4;

   localparam logic [2:0] CSR_WINDOW_MS    = 3'd0;
   localparam logic [2:0] CSR_MAX_REQUESTS = 3'd1;
   localparam logic [2:0] CSR_MAX_FAILURES = 3'd2;
   localparam logic [2:0] CSR_BLOCK_MS     = 3'd3;
   localparam logic [2:0] CSR_IDLE_MS      = 3'd4;
   localparam logic [2:0] CSR_CLEANUP_MS   = 3'd5;

   localparam logic [31:0] WINDOW_MS_RST    = 32'd1000;
   localparam logic [3:0]  MAX_REQUESTS_RST = 4'd5;
   localparam logic [7:0]  MAX_FAILURES_RST = 8'd5;
   localparam logic [31:0] BLOCK_MS_RST     = 32'd300000;
   localparam logic [31:0] IDLE_MS_RST      = 32'd300000;
   localparam logic [31:0] CLEANUP_MS_RST   = 32'd300000;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] src_addr;
      logic [31:0] now_ms;
      logic        allowed;
   } req_type;

   typedef struct packed {
      logic limited;
      logic blocked;
      logic table_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0] window_ms;
      logic [3:0]  max_requests;
      logic [7:0]  max_failures;
      logic [31:0] block_ms;
      logic [31:0] idle_ms;
      logic [31:0] cleanup_period_ms;
   } cfg_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_QUERY_LIMITED,
      KIND_RECORD_REQ,
      KIND_RECORD_FAIL,
      KIND_QUERY_BLOCKED,
      KIND_CLEANUP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] src_addr;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [7:0]  fail_count;
      logic [31:0] block_deadline;
      logic [31:0] last_seen;
   } rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DISPATCH,
      ST_PRUNE_RD,
      ST_PRUNE_CHK,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

FILE: hw/rtl/per_source_rate_limiter.sv
// ---------------------------------------------------------------------------
// per_source_rate_limiter
// per-source sliding window rate limiter with failure blocking
// ---------------------------------------------------------------------------
//  channel  ports                            direction  moves
//  req      req_valid/ready, req_data        in         one operation per transaction
//  rsp      rsp_valid/ready, rsp_data        out        one result per operation
//  csr      csr_valid/ready, csr_index/data  in         one register write
//
//  an operation scans the whole table in the engine, reading then comparing
//  each entry in turn, then dispatches; a record that takes or updates an
//  entry adds an update step, and a rate query that prunes reads and checks
//  each stored stamp; a no-op or skipped cleanup goes straight to the result
//  reset clears the table valid bits at once, no clearing pass
//  two operations queue up in front while a result waits on rsp_ready
// ---------------------------------------------------------------------------
module per_source_rate_limiter import psrl_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int STAMPS  = STAMPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type  cfg_ff;
   logic     q_full;
   logic     q_push;
   item_type q_in;
   logic     q_pop;
   logic     q_empty;
   item_type q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms         <= WINDOW_MS_RST;
         cfg_ff.max_requests      <= MAX_REQUESTS_RST;
         cfg_ff.max_failures      <= MAX_FAILURES_RST;
         cfg_ff.block_ms          <= BLOCK_MS_RST;
         cfg_ff.idle_ms           <= IDLE_MS_RST;
         cfg_ff.cleanup_period_ms <= CLEANUP_MS_RST;
      end else if (csr_valid) begin
         priority case (csr_index)
            CSR_WINDOW_MS:    cfg_ff.window_ms         <= csr_data;
            CSR_MAX_REQUESTS: cfg_ff.max_requests      <= csr_data[3:0];
            CSR_MAX_FAILURES: cfg_ff.max_failures      <= csr_data[7:0];
            CSR_BLOCK_MS:     cfg_ff.block_ms          <= csr_data;
            CSR_IDLE_MS:      cfg_ff.idle_ms           <= csr_data;
            CSR_CLEANUP_MS:   cfg_ff.cleanup_period_ms <= csr_data;
            default: begin
            end
         endcase
      end
   end

   psrl_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in)
   );

   psrl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head)
   );

   psrl_engine #(
      .ENTRIES (ENTRIES),
      .STAMPS  (STAMPS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/psrl_front.sv
// ---------------------------------------------------------------------------
// psrl_front
// accepts request transactions and classifies them for the engine
// ---------------------------------------------------------------------------
module psrl_front import psrl_pkg::*; (
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output item_type q_item
);

   kind_type kind;

   // allowlisted sources skip queries and failure counting
   always_comb begin
      unique case (req_data.op)
         OP_QUERY_LIMITED: kind = req_data.allowed ? KIND_NONE : KIND_QUERY_LIMITED;
         OP_RECORD_REQ:    kind = KIND_RECORD_REQ;
         OP_RECORD_FAIL:   kind = req_data.allowed ? KIND_NONE : KIND_RECORD_FAIL;
         OP_QUERY_BLOCKED: kind = req_data.allowed ? KIND_NONE : KIND_QUERY_BLOCKED;
         OP_CLEANUP:       kind = KIND_CLEANUP;
         default:          kind = KIND_NONE;
      endcase
   end

   assign req_ready       = !q_full;
   assign q_push          = req_valid && !q_full;
   assign q_item.kind     = kind;
   assign q_item.src_addr = req_data.src_addr;
   assign q_item.now_ms   = req_data.now_ms;

endmodule

FILE: hw/rtl/psrl_queue.sv
// ---------------------------------------------------------------------------
// psrl_queue
// short fifo between the front and the engine
// ---------------------------------------------------------------------------
module psrl_queue import psrl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head_item
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

   item_type      slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/psrl_engine.sv
// ---------------------------------------------------------------------------
// psrl_engine
// scans the source table and carries out one operation at a time
// ---------------------------------------------------------------------------
`include "per_source_rate_limiter_defines.svh"

module psrl_engine import psrl_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int STAMPS  = STAMPS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_empty,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW = (STAMPS > 1) ? $clog2(STAMPS) : 1;
   localparam int FW = $clog2(STAMPS + 1);
   localparam int RD = ENTRIES * STAMPS;
   localparam int RW = (RD > 1) ? $clog2(RD) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(STAMPS);
   localparam logic [SW:0]   STAMPS_X = (SW + 1)'(STAMPS);

   function automatic logic [SW-1:0] slot_add(logic [SW-1:0] a, logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= STAMPS_X) begin
         s = s - STAMPS_X;
      end
      return s[SW-1:0];
   endfunction

   function automatic logic [RW-1:0] ring_addr(logic [IW-1:0] e, logic [SW-1:0] s);
      return RW'(e) * RW'(STAMPS) + RW'(s);
   endfunction

   // table storage
   rec_type       rec_mem  [ENTRIES];
   logic [FW-1:0] fill_mem [ENTRIES];
   logic [SW-1:0] head_mem [ENTRIES];
   logic [31:0]   ring_mem [RD];

   rec_type       rec_q;
   logic [FW-1:0] fill_q;
   logic [SW-1:0] head_q;
   logic [31:0]   ring_q;

   state_type     state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff;
   logic [31:0]   last_cleanup_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   kind_type      kind_ff;
   logic [31:0]   addr_ff;
   logic [31:0]   now_ff;
   logic [IW-1:0] idx_ff;
   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [IW-1:0] free_idx_ff;
   rec_type       rec_ff;
   logic [FW-1:0] fill_ff;
   logic [SW-1:0] head_ff;
   logic [FW-1:0] k_ff;
   logic [FW-1:0] kept_ff;
   rsp_type       res_ff;

   // control outputs
   logic          rec_re;
   logic          rec_we;
   rec_type       rec_wdata;
   logic [FW-1:0] fill_wdata;
   logic [SW-1:0] head_wdata;
   logic          ring_re;
   logic [RW-1:0] ring_raddr;
   logic          ring_we;
   logic [RW-1:0] ring_waddr;
   logic [31:0]   ring_wdata;
   logic          rsp_load;

   logic          clean_go;
   logic          is_blocked;
   logic          in_window;
   logic          prune_lim;
   logic [7:0]    fail_inc;
   logic          fail_trip;
   logic          entry_match;
   logic          entry_idle;

   assign clean_go    = (q_item.now_ms - last_cleanup_ff) > cfg.cleanup_period_ms;
   assign is_blocked  = rec_ff.block_deadline > now_ff;
   assign in_window   = (now_ff - ring_q) <= cfg.window_ms;
   assign prune_lim   = 32'(kept_ff) >= 32'(cfg.max_requests);
   assign fail_inc    = (rec_ff.fail_count != 8'hFF) ? rec_ff.fail_count + 8'd1
                                                     : rec_ff.fail_count;
   assign fail_trip   = fail_inc >= cfg.max_failures;
   assign entry_match = valid_ff[idx_ff] && (rec_q.addr == addr_ff);
   assign entry_idle  = (now_ff - rec_q.last_seen) > cfg.idle_ms;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if ((q_item.kind == KIND_NONE) || ((q_item.kind == KIND_CLEANUP) && !clean_go)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = (idx_ff == LAST_IDX) ? ST_DISPATCH : ST_SCAN_RD;
         ST_DISPATCH: begin
            priority case (kind_ff)
               KIND_QUERY_LIMITED: state_in = (hit_ff && !is_blocked) ? ST_PRUNE_RD : ST_RESP;
               KIND_RECORD_REQ,
               KIND_RECORD_FAIL:   state_in = (hit_ff || free_ff) ? ST_UPDATE : ST_RESP;
               default:            state_in = ST_RESP;
            endcase
         end
         ST_PRUNE_RD:  state_in = (k_ff == fill_ff) ? ST_RESP : ST_PRUNE_CHK;
         ST_PRUNE_CHK: state_in = ST_PRUNE_RD;
         ST_UPDATE:    state_in = ST_RESP;
         ST_RESP:      state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop      = 1'b0;
      rec_re     = 1'b0;
      rec_we     = 1'b0;
      rec_wdata  = rec_ff;
      fill_wdata = fill_ff;
      head_wdata = head_ff;
      ring_re    = 1'b0;
      ring_raddr = ring_addr(hit_idx_ff, slot_add(head_ff, SW'(k_ff)));
      ring_we    = 1'b0;
      ring_waddr = ring_addr(hit_idx_ff, slot_add(head_ff, SW'(kept_ff)));
      ring_wdata = ring_q;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    q_pop  = !q_empty;
         ST_SCAN_RD: rec_re = 1'b1;
         ST_PRUNE_RD: begin
            if (k_ff != fill_ff) begin
               ring_re = 1'b1;
            end else begin
               rec_we     = 1'b1;
               fill_wdata = kept_ff;
            end
         end
         ST_PRUNE_CHK: ring_we = in_window;
         ST_UPDATE: begin
            rec_we = 1'b1;
            if (kind_ff == KIND_RECORD_REQ) begin
               ring_we             = 1'b1;
               ring_wdata          = now_ff;
               rec_wdata.last_seen = now_ff;
               if (fill_ff < FULL_FILL) begin
                  ring_waddr = ring_addr(hit_idx_ff, slot_add(head_ff, SW'(fill_ff)));
                  fill_wdata = fill_ff + 1'b1;
               end else begin
                  // store full: the oldest stamp gives way
                  ring_waddr = ring_addr(hit_idx_ff, head_ff);
                  head_wdata = slot_add(head_ff, SW'(1));
               end
            end else begin
               if (fail_trip) begin
                  rec_wdata.fail_count     = 8'd0;
                  rec_wdata.block_deadline = now_ff + cfg.block_ms;
               end else begin
                  rec_wdata.fail_count = fail_inc;
               end
            end
         end
         ST_RESP:  rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         valid_ff        <= '0;
         last_cleanup_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == ST_SCAN_CMP) && (kind_ff == KIND_CLEANUP) &&
             valid_ff[idx_ff] && entry_idle) begin
            valid_ff[idx_ff] <= 1'b0;
         end
         if (state_ff == ST_DISPATCH) begin
            if (((kind_ff == KIND_RECORD_REQ) || (kind_ff == KIND_RECORD_FAIL)) &&
                !hit_ff && free_ff) begin
               valid_ff[free_idx_ff] <= 1'b1;
            end
            if (kind_ff == KIND_CLEANUP) begin
               last_cleanup_ff <= now_ff;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               kind_ff <= q_item.kind;
               addr_ff <= q_item.src_addr;
               now_ff  <= q_item.now_ms;
               idx_ff  <= '0;
               hit_ff  <= 1'b0;
               free_ff <= 1'b0;
               res_ff  <= '0;
            end
         end
         ST_SCAN_CMP: begin
            if (entry_match && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx_ff;
               rec_ff     <= rec_q;
               fill_ff    <= fill_q;
               head_ff    <= head_q;
            end
            if (!valid_ff[idx_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= idx_ff;
            end
            if (idx_ff != LAST_IDX) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_DISPATCH: begin
            k_ff    <= '0;
            kept_ff <= '0;
            if (kind_ff == KIND_QUERY_LIMITED) begin
               res_ff.limited <= hit_ff && is_blocked;
            end
            if (kind_ff == KIND_QUERY_BLOCKED) begin
               res_ff.blocked <= hit_ff && is_blocked;
            end
            if (((kind_ff == KIND_RECORD_REQ) || (kind_ff == KIND_RECORD_FAIL)) && !hit_ff) begin
               if (free_ff) begin
                  hit_idx_ff            <= free_idx_ff;
                  rec_ff.addr           <= addr_ff;
                  rec_ff.fail_count     <= 8'd0;
                  rec_ff.block_deadline <= 32'd0;
                  rec_ff.last_seen      <= 32'd0;
                  fill_ff               <= '0;
                  head_ff               <= '0;
               end else begin
                  res_ff.table_full <= 1'b1;
               end
            end
         end
         ST_PRUNE_RD: begin
            if (k_ff == fill_ff) begin
               res_ff.limited <= prune_lim;
            end
         end
         ST_PRUNE_CHK: begin
            k_ff <= k_ff + 1'b1;
            if (in_window) begin
               kept_ff <= kept_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_data_ff <= res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[hit_idx_ff]  <= rec_wdata;
         fill_mem[hit_idx_ff] <= fill_wdata;
         head_mem[hit_idx_ff] <= head_wdata;
      end
      if (rec_re) begin
         rec_q  <= rec_mem[idx_ff];
         fill_q <= fill_mem[idx_ff];
         head_q <= head_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (ring_re) begin
         ring_q <= ring_mem[ring_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PSRL_ASSERT_IMPL(a_pop_idle, clock, reset, q_pop, state_ff == ST_IDLE, "pop outside idle")
   `PSRL_ASSERT_IMPL(a_load_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `PSRL_ASSERT_NEXT(a_load_done, clock, reset, rsp_load, (state_ff == ST_IDLE) && rsp_valid_ff, "result lost")
   `PSRL_ASSERT_IMPL(a_prune_kept, clock, reset, state_ff == ST_PRUNE_RD, (kept_ff <= k_ff) && (k_ff <= fill_ff), "prune count")
   `PSRL_ASSERT_IMPL(a_fill_bound, clock, reset, state_ff == ST_UPDATE, fill_ff <= FULL_FILL, "stamp fill overflow")

endmodule
